FILE: design/rac_pkg.sv
package rac_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int KIND_W = 2;
  localparam int CHAR_W = 7;
  localparam int POS_W = 4;
  localparam int DIGIT_W = 4;

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 4'd10;

  typedef enum logic [KIND_W-1:0] {
    KIND_DEC    = 2'd0,
    KIND_OCT    = 2'd1,
    KIND_HEX_LO = 2'd2,
    KIND_HEX_UP = 2'd3
  } rac_kind_t;

  // ascii code of one digit value 0..15
  function automatic logic [CHAR_W-1:0] rac_char(input logic [DIGIT_W-1:0] d,
                                                 input logic upper);
    logic [CHAR_W-1:0] base;
    logic [CHAR_W-1:0] ofs;
    if (d < DIGIT_TEN) begin
      base = CHAR_ZERO;
      ofs  = CHAR_W'(d);
    end else begin
      base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
      ofs  = CHAR_W'(d - DIGIT_TEN);
    end
    return base + ofs;
  endfunction

endpackage

FILE: design/rac_if.sv
interface rac_in_if import rac_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;
  logic [KIND_W-1:0]      kind;

  modport source (output valid, output value, output kind, input ready);
  modport sink (input valid, input value, input kind, output ready);
endinterface

interface rac_out_if import rac_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] digit_char;
  logic [POS_W-1:0]  digit_position;
  logic              last_digit;

  modport source (output valid, output digit_char, output digit_position,
                  output last_digit, input ready);
  modport sink (input valid, input digit_char, input digit_position,
                input last_digit, output ready);
endinterface

FILE: design/rac_conv.sv
module rac_conv import rac_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int NDIG = (VALUE_WIDTH + 2) / 3
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [VALUE_WIDTH-1:0]  value,
  input  logic [KIND_W-1:0]       kind,
  input  logic                    take,
  output logic                    idle,
  output logic                    done,
  output logic                    upper,
  output logic [NDIG*DIGIT_W-1:0] digits
);

  localparam int CW = $clog2(VALUE_WIDTH);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

  state_t                  state;
  logic [NDIG*DIGIT_W-1:0] bcd;
  logic [NDIG*DIGIT_W-1:0] adj;
  logic [NDIG*DIGIT_W-1:0] oct;
  logic [NDIG*3-1:0]       vpad;
  logic [VALUE_WIDTH-1:0]  sh;
  logic [CW-1:0]           cnt;
  rac_kind_t               kind_in;

  assign kind_in = rac_kind_t'(kind);
  assign vpad    = (NDIG*3)'(value);

  // add-3 correction on every bcd digit before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + 4'd3;
      end else begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W];
      end
      oct[i*DIGIT_W +: DIGIT_W] = {1'b0, vpad[i*3 +: 3]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            upper <= (kind_in == KIND_HEX_UP);
            unique case (kind_in)
              KIND_DEC: begin
                bcd   <= '0;
                sh    <= value;
                cnt   <= CW'(VALUE_WIDTH - 1);
                state <= S_RUN;
              end
              KIND_OCT: begin
                bcd   <= oct;
                state <= S_DONE;
              end
              default: begin
                bcd   <= (NDIG*DIGIT_W)'(value);
                state <= S_DONE;
              end
            endcase
          end
        end
        S_RUN: begin
          bcd <= {adj[NDIG*DIGIT_W-2:0], sh[VALUE_WIDTH-1]};
          sh  <= sh << 1;
          if (cnt == '0) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign idle   = (state == S_IDLE);
  assign done   = (state == S_DONE);
  assign digits = bcd;

`ifndef SYNTHESIS
  a_take_from_done: assert property (@(posedge clk) disable iff (rst)
    take |-> state == S_DONE) else $error("digits taken before conversion done");
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && cnt == '0) |=> state == S_DONE)
    else $error("conversion did not finish after last bit");
  a_start_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    start |=> (state == S_RUN || state == S_DONE))
    else $error("accepted value did not start conversion");
`endif

endmodule

FILE: design/rac_emit.sv
module rac_emit import rac_pkg::*; #(
  parameter int NDIG = (VALUE_WIDTH_DEF + 2) / 3
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    done,
  input  logic                    upper,
  input  logic [NDIG*DIGIT_W-1:0] digits,
  output logic                    take,
  rac_out_if.source               out_ch
);

  localparam int RW = $clog2(NDIG + 1);

  typedef enum logic [1:0] {S_IDLE, S_SKIP, S_EMIT} state_t;

  state_t                  state;
  logic [NDIG*DIGIT_W-1:0] dig;
  logic [DIGIT_W-1:0]      top;
  logic [RW-1:0]           remain;
  logic [POS_W-1:0]        pos;
  logic                    up;
  logic                    out_free;

  assign top      = dig[NDIG*DIGIT_W-1 -: DIGIT_W];
  assign out_free = !out_ch.valid || out_ch.ready;
  assign take     = (state == S_IDLE) && done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_ch.valid <= 1'b0;
    end else begin
      // while emitting, valid is decided in the emit arm alone
      if (out_ch.ready && state != S_EMIT) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (done) begin
            dig    <= digits;
            up     <= upper;
            remain <= RW'(NDIG);
            pos    <= POS_W'(1);
            state  <= S_SKIP;
          end
        end
        S_SKIP: begin
          // drop leading zeros, keep at least one digit
          if (top == '0 && remain != RW'(1)) begin
            dig    <= dig << DIGIT_W;
            remain <= remain - 1'b1;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_ch.valid          <= 1'b1;
            out_ch.digit_char     <= rac_char(top, up);
            out_ch.digit_position <= pos;
            out_ch.last_digit     <= (remain == RW'(1));
            dig    <= dig << DIGIT_W;
            remain <= remain - 1'b1;
            pos    <= pos + 1'b1;
            if (remain == RW'(1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_take_starts_skip: assert property (@(posedge clk) disable iff (rst)
    take |=> state == S_SKIP) else $error("handoff did not start digit scan");
  a_remain_nonzero: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> remain != '0) else $error("digit count ran out while busy");
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && out_free && remain == RW'(1)) |=>
      (state == S_IDLE && out_ch.valid && out_ch.last_digit))
    else $error("final digit not flagged or run not closed");
`endif

endmodule

FILE: design/radix_ascii_converter.sv
// path to first beat: decimal values pass the bit loop, then leading zero digits are skipped;
//   octal and hex skip the bit loop and go straight to the leading zero skip
// throughput: digits leave at one beat per cycle while out_ch.ready holds; a new value is taken
//   once the converter has handed its digits on, so decimal runs are paced by the
//   one-bit-per-cycle double-dabble loop
// reset: synchronous active-high rst empties both stages and drops out valid
module radix_ascii_converter import rac_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  rac_in_if.sink    in_ch,
  rac_out_if.source out_ch
);

  // one 4-bit slot per octal digit covers decimal and hex too
  localparam int NDIG = (VALUE_WIDTH + 2) / 3;

  logic                    conv_idle;
  logic                    conv_done;
  logic                    conv_upper;
  logic                    take;
  logic [NDIG*DIGIT_W-1:0] digits;

  // a new value is taken whenever the converter holds nothing
  assign in_ch.ready = conv_idle;

  // bit-serial binary to bcd for decimal, direct digit slicing for octal and hex
  rac_conv #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NDIG        (NDIG)
  ) u_conv (
    .clk    (clk),
    .rst    (rst),
    .start  (in_ch.valid && in_ch.ready),
    .value  (in_ch.value),
    .kind   (in_ch.kind),
    .take   (take),
    .idle   (conv_idle),
    .done   (conv_done),
    .upper  (conv_upper),
    .digits (digits)
  );

  // digit shifter: skips leading zeros, then one ascii beat per digit,
  // most significant first, with position and last flag
  rac_emit #(
    .NDIG (NDIG)
  ) u_emit (
    .clk    (clk),
    .rst    (rst),
    .done   (conv_done),
    .upper  (conv_upper),
    .digits (digits),
    .take   (take),
    .out_ch (out_ch)
  );

endmodule
